### hdl/gas_sensor_power_law_conversion_macros.svh
// Assertion macros for the gas sensor power-law conversion block.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef GAS_SENSOR_POWER_LAW_CONVERSION_MACROS_SVH
`define GAS_SENSOR_POWER_LAW_CONVERSION_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define GSPL_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gspl: implication check failed");

// Next-cycle implication, disabled while in reset.
`define GSPL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gspl: next-cycle check failed");

`endif

### hdl/gspl_pkg.sv
// Package for the gas sensor power-law conversion: payload structs, register
// indices, status codes, reset values and the exp2 root constant function.
// No dependencies.
package gspl_pkg;

	localparam int SAMPLE_BITS       = 12;
	localparam int DEF_FRACTION_BITS = 16;
	localparam int COEF_BITS         = 16;
	localparam int EXPO_BITS         = 17;
	localparam int CORR_BITS         = 16;
	localparam int CONC_BITS         = 21;
	localparam int MAG_BITS          = CONC_BITS + 2;

	localparam logic [COEF_BITS-1:0] COEF_RESET = 16'd10682;
	localparam logic [EXPO_BITS-1:0] EXPO_RESET = 17'd65444;

	localparam logic REG_COEFFICIENT_A = 1'b0;
	localparam logic REG_EXPONENT_M    = 1'b1;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_SENSOR_ZERO = 2'd1;
	localparam logic [1:0] ST_SENSOR_HIGH = 2'd2;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0]      supply_sample;
		logic [SAMPLE_BITS-1:0]      sensor_sample;
		logic signed [CORR_BITS-1:0] offset_correction;
	} gspl_in_t;

	typedef struct packed {
		logic signed [CONC_BITS-1:0] concentration;
		logic [1:0]                  status;
	} gspl_out_t;

	function automatic logic [63:0] gspl_isqrt(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] v;
		r = '0;
		v = x;
		b = 64'h4000_0000_0000_0000;
		for (int n = 0; n < 32; n++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-i) with fb fraction bits, by repeated integer square roots from 2
	function automatic logic [63:0] gspl_exp2_root(input int fb, input int i);
		logic [63:0] root;
		root = 64'd2 << fb;
		for (int k = 1; k <= i; k++)
			root = gspl_isqrt(root << fb);
		return root;
	endfunction

endpackage

### hdl/gas_sensor_power_law_conversion.sv
// Gas sensor power-law conversion, top level and full pipeline.
// Depends on gspl_pkg and gas_sensor_power_law_conversion_macros.svh.
//
// Usage: sample (valid/ready) carries supply_sample, sensor_sample and
// offset_correction; result (valid/ready) returns concentration (1/1024 ppm,
// saturated) and status. cfg_wr_en/cfg_index/cfg_data write coefficient_a
// (index 0) and exponent_m (index 1); write only while the pipeline is empty.
// Throughput: one transaction per cycle while the result is not stalled.
// The pipeline holds the input stage, the one-bit-per-stage divider, the
// leading-zero stages, one squaring stage per log2 fraction bit, the exponent
// product stage, one root product stage per exp2 fraction bit, and the
// coefficient, scaling and saturation stages.
// Reset empties the pipeline and restores the register defaults.
// When the receiver stalls a finished result, the whole pipeline holds and
// sample_ready drops; nothing is lost or repeated.
`include "gas_sensor_power_law_conversion_macros.svh"

module gas_sensor_power_law_conversion
	import gspl_pkg::*;
#(
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [EXPO_BITS-1:0] cfg_data,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  gspl_in_t             sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output gspl_out_t            result
);

	localparam int F    = FRACTION_BITS;
	localparam int SB   = SAMPLE_BITS;
	localparam int QW   = SB + F;
	localparam int LZN  = $clog2(QW);
	localparam int IW   = $clog2(QW) + 1;
	localparam int LW   = IW + F;
	localparam int TW   = LW + 2;
	localparam int KW   = TW - F;
	localparam int SHW  = KW + 6;
	localparam int AW   = COEF_BITS + F + 1;
	localparam int MW   = MAG_BITS;
	localparam int SUMW = MW + 2;

	localparam int DIV0 = 1;
	localparam int LZ0  = DIV0 + QW;
	localparam int SQ0  = LZ0 + LZN;
	localparam int MULI = SQ0 + F;
	localparam int EX0  = MULI + 1;
	localparam int APS  = EX0 + F;
	localparam int SHF  = APS + 1;
	localparam int FIN  = SHF + 1;
	localparam int NST  = FIN + 1;

	localparam logic [MW-1:0] MAG_CLIP = MW'(1) << (MW - 1);
	localparam logic signed [SUMW-1:0] CONC_MAX = SUMW'((1 << (CONC_BITS - 1)) - 1);
	localparam logic signed [SUMW-1:0] CONC_MIN = -SUMW'(1 << (CONC_BITS - 1));

	typedef struct packed {
		logic [1:0]                  status;
		logic signed [CORR_BITS-1:0] corr;
		logic [QW-1:0]               num;
		logic [SB-1:0]               rem;
		logic [SB-1:0]               dvs;
		logic [QW-1:0]               quo;
		logic [LZN-1:0]              lz;
		logic                        rzero;
		logic [F:0]                  y;
		logic [F-1:0]                frac;
		logic signed [TW-1:0]        t;
		logic                        kill;
		logic [F:0]                  acc;
		logic [AW-1:0]               ap;
		logic [MW-1:0]               magc;
		logic signed [CONC_BITS-1:0] conc;
	} pipe_t;

	logic [COEF_BITS-1:0] coef_q;
	logic [EXPO_BITS-1:0] expo_q;
	pipe_t                nxt [NST];
	pipe_t                pipe_s [NST];
	logic [NST-1:0]       valid_s;
	logic                 en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
			expo_q <= EXPO_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_COEFFICIENT_A: coef_q <= cfg_data[COEF_BITS-1:0];
				REG_EXPONENT_M:    expo_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	assign en           = !valid_s[NST-1] || result_ready;
	assign sample_ready = en;

	always_comb begin
		nxt[0]      = '0;
		nxt[0].corr = sample.offset_correction;
		nxt[0].dvs  = sample.sensor_sample;
		nxt[0].num  = {sample.supply_sample - sample.sensor_sample, {F{1'b0}}};
		if (sample.sensor_sample == '0)
			nxt[0].status = ST_SENSOR_ZERO;
		else if (sample.sensor_sample > sample.supply_sample)
			nxt[0].status = ST_SENSOR_HIGH;
		else
			nxt[0].status = ST_OK;
	end

	for (genvar g = DIV0; g < LZ0; g++) begin : g_div
		logic [SB:0] rsh;
		always_comb begin
			nxt[g] = pipe_s[g-1];
			rsh    = {pipe_s[g-1].rem, pipe_s[g-1].num[QW-1]};
			nxt[g].num = pipe_s[g-1].num << 1;
			if (rsh >= {1'b0, pipe_s[g-1].dvs}) begin
				nxt[g].rem = SB'(rsh - {1'b0, pipe_s[g-1].dvs});
				nxt[g].quo = {pipe_s[g-1].quo[QW-2:0], 1'b1};
			end else begin
				nxt[g].rem = rsh[SB-1:0];
				nxt[g].quo = {pipe_s[g-1].quo[QW-2:0], 1'b0};
			end
		end
	end

	for (genvar g = LZ0; g < SQ0; g++) begin : g_lz
		localparam int AMT = 1 << (LZN - 1 - (g - LZ0));
		always_comb begin
			nxt[g] = pipe_s[g-1];
			if (g == LZ0) begin
				nxt[g].rzero = (pipe_s[g-1].quo == '0);
				nxt[g].lz    = '0;
			end
			if (pipe_s[g-1].quo[QW-1 -: AMT] == '0) begin
				nxt[g].quo = pipe_s[g-1].quo << AMT;
				nxt[g].lz  = nxt[g].lz + LZN'(AMT);
			end
		end
	end

	for (genvar g = SQ0; g < MULI; g++) begin : g_sq
		logic [F:0]     ysrc;
		logic [2*F+1:0] sq;
		always_comb begin
			nxt[g] = pipe_s[g-1];
			ysrc   = (g == SQ0) ? pipe_s[g-1].quo[QW-1 -: F+1] : pipe_s[g-1].y;
			sq     = ysrc * ysrc;
			if (sq[2*F+1]) begin
				nxt[g].y                      = sq[2*F+1:F+1];
				nxt[g].frac[F-1-(g-SQ0)]      = 1'b1;
			end else begin
				nxt[g].y                      = sq[2*F:F];
				nxt[g].frac[F-1-(g-SQ0)]      = 1'b0;
			end
		end
	end

	logic signed [IW-1:0]    ipart;
	logic signed [LW-1:0]    logv;
	logic signed [LW+17:0]   prod;
	always_comb begin
		nxt[MULI] = pipe_s[MULI-1];
		ipart     = IW'(SB - 1) - {{(IW-LZN){1'b0}}, pipe_s[MULI-1].lz};
		logv      = {ipart, pipe_s[MULI-1].frac};
		prod      = $signed({1'b0, expo_q}) * logv;
		nxt[MULI].t    = pipe_s[MULI-1].rzero ? '0 : prod[16 +: TW];
		nxt[MULI].kill = (pipe_s[MULI-1].rzero && expo_q != '0) || coef_q == '0;
	end

	for (genvar g = EX0; g < APS; g++) begin : g_exp
		localparam logic [F:0] ROOT = (F+1)'(gspl_exp2_root(F, g - EX0 + 1));
		logic [F:0]     asrc;
		logic [2*F+1:0] pr;
		always_comb begin
			nxt[g] = pipe_s[g-1];
			asrc   = (g == EX0) ? (F+1)'(1) << F : pipe_s[g-1].acc;
			pr     = asrc * ROOT;
			nxt[g].acc = pipe_s[g-1].t[F-1-(g-EX0)] ? pr[2*F:F] : asrc;
		end
	end

	always_comb begin
		nxt[APS]    = pipe_s[APS-1];
		nxt[APS].ap = coef_q * pipe_s[APS-1].acc;
	end

	logic signed [KW-1:0]  kpart;
	logic signed [SHW-1:0] sh;
	logic [SHW-1:0]        rs;
	logic [AW-1:0]         tmpr;
	logic [AW+MW-2:0]      tmpl;
	always_comb begin
		nxt[SHF] = pipe_s[SHF-1];
		kpart    = pipe_s[SHF-1].t[TW-1:F];
		sh       = {{(SHW-KW){kpart[KW-1]}}, kpart} - SHW'(F + 6);
		rs       = -sh;
		tmpr     = pipe_s[SHF-1].ap >> rs;
		tmpl     = {{(MW-1){1'b0}}, pipe_s[SHF-1].ap} << sh[$clog2(MW)-1:0];
		if (pipe_s[SHF-1].kill)
			nxt[SHF].magc = '0;
		else if (sh < 0) begin
			if (rs >= SHW'(AW))
				nxt[SHF].magc = '0;
			else if (tmpr[AW-1:MW-1] != '0)
				nxt[SHF].magc = MAG_CLIP;
			else
				nxt[SHF].magc = tmpr[MW-1:0];
		end else if (sh > $signed(SHW'(MW - 1)))
			nxt[SHF].magc = MAG_CLIP;
		else if (tmpl[AW+MW-2:MW-1] != '0)
			nxt[SHF].magc = MAG_CLIP;
		else
			nxt[SHF].magc = tmpl[MW-1:0];
	end

	logic signed [SUMW-1:0] sum;
	always_comb begin
		nxt[FIN] = pipe_s[FIN-1];
		sum      = $signed({2'b00, pipe_s[FIN-1].magc})
			+ {{(SUMW-CORR_BITS){pipe_s[FIN-1].corr[CORR_BITS-1]}}, pipe_s[FIN-1].corr};
		if (pipe_s[FIN-1].status != ST_OK)
			nxt[FIN].conc = '0;
		else if (sum > CONC_MAX)
			nxt[FIN].conc = CONC_MAX[CONC_BITS-1:0];
		else if (sum < CONC_MIN)
			nxt[FIN].conc = CONC_MIN[CONC_BITS-1:0];
		else
			nxt[FIN].conc = sum[CONC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s <= '0;
		else if (en)
			valid_s <= {valid_s[NST-2:0], sample_valid};
	end

	always_ff @(posedge clk) begin
		if (en)
			pipe_s <= nxt;
	end

	assign result_valid         = valid_s[NST-1];
	assign result.concentration = pipe_s[NST-1].conc;
	assign result.status        = pipe_s[NST-1].status;

	`GSPL_ASSERT_IMPLY(a_error_zero, result_valid && result.status != ST_OK, result.concentration == '0)
	`GSPL_ASSERT_IMPLY(a_stall_blocks, result_valid && !result_ready, !sample_ready)
	`GSPL_ASSERT_NEXT(a_stall_holds, result_valid && !result_ready, result_valid && $stable(valid_s))

endmodule
